FILE: src/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text converter
// Holds the sequencer states, the cell control bundle and ASCII codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int BCD_W               = 4;
  localparam int CHAR_W              = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'd45;

  // Sequencer states of the converter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Control shared by every cell of the digit chain.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 adjust, then shift one binary bit in
    logic move;    // take the neighbor's digit (shift toward the top)
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts a two's-complement value into its decimal characters, most
// significant first, with an optional leading minus sign.
// ----------------------------------------------------------------------------
// The block takes one VALUE_WIDTH-bit signed value per in_ valid/ready
// transfer and returns its decimal text one character per out_ transfer:
// a '-' for negative values, then the digits without leading zeros, with
// out_last high on the final digit. Zero gives the single character '0',
// and the most negative value is converted exactly. The magnitude runs
// through a chain of BCD digit cells (shift and add-3), one binary bit per
// cycle, until all VALUE_WIDTH bits are in. The same chain then shifts
// toward the output: leading zero digits are dropped at one per cycle,
// then the top digit is found to be the first one to show, and each
// character is loaded into the output register when the output side is
// free. One item is in work at a time; a new item is taken as soon as
// the last character sits in the output register, while that character
// still waits to be transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [VALUE_WIDTH-1:0]        in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);
  import sitda_pkg::*;

  // Number of decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude.
  // 1233/4096 approximates log10(2) closely enough for widths up to 64.
  localparam int NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int CNT_W      = $clog2(VALUE_WIDTH);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic                   neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [CHAR_W-1:0] load_char;
  logic              load_last;
  cell_ctrl_t        ctrl;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] abs_value;

  logic [BCD_W-1:0] digit_w [NUM_DIGITS];
  logic             carry_w [NUM_DIGITS];
  logic [BCD_W-1:0] top_digit;
  logic             top_zero;
  logic             rem_one;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign top_digit = digit_w[NUM_DIGITS-1];
  assign top_zero  = (top_digit == '0);
  assign rem_one   = (rem_r == REM_W'(1));

  // Magnitude in an unsigned word of the same width: the most negative
  // value maps onto 2^(VALUE_WIDTH-1), which still fits.
  assign raw       = in_value;
  assign abs_value = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

  // Digit chain: cell 0 holds the least significant digit. Binary bits
  // enter at cell 0 and carries climb; for output, digits also climb and
  // the top cell is the one shown.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic             bit_in;
    logic [BCD_W-1:0] digit_in;

    if (i == 0) begin : g_first
      assign bit_in   = mag_r[VALUE_WIDTH-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry_w[i-1];
      assign digit_in = digit_w[i-1];
    end

    sitda_bcd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .carry_out (carry_w[i]),
      .digit     (digit_w[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(top_zero && !rem_one)) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free && rem_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell control, counters and output loads.
  always_comb begin
    in_ready  = 1'b0;
    ctrl      = '0;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    out_load  = 1'b0;
    load_char = ASCII_ZERO + CHAR_W'(top_digit);
    load_last = rem_one;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.clear = 1'b1;
          mag_nxt    = abs_value;
          neg_nxt    = raw[VALUE_WIDTH-1];
          cnt_nxt    = CNT_W'(VALUE_WIDTH - 1);
          rem_nxt    = REM_W'(NUM_DIGITS);
        end
      end
      ST_CONVERT: begin
        ctrl.dabble = 1'b1;
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt     = cnt_r - CNT_W'(1);
      end
      ST_SKIP: begin
        // Drop leading zero digits but always keep the last one.
        if (top_zero && !rem_one) begin
          ctrl.move = 1'b1;
          rem_nxt   = rem_r - REM_W'(1);
        end
      end
      ST_SIGN: begin
        load_char = MINUS_SIGN;
        load_last = 1'b0;
        out_load  = out_free;
      end
      ST_DIGITS: begin
        if (out_free) begin
          out_load  = 1'b1;
          ctrl.move = 1'b1;
          rem_nxt   = rem_r - REM_W'(1);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Output register: holds a character until the consumer takes it.
  always_comb begin
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = load_char;
      out_last_nxt  = load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: src/sitda_bcd_cell.sv
// ----------------------------------------------------------------------------
// sitda_bcd_cell: one decimal digit of the conversion chain
// Holds one BCD digit, does the add-3 shift step of binary to BCD
// conversion and moves digits up the chain for output.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_bcd_cell (
  input  wire                         clk,
  input  wire sitda_pkg::cell_ctrl_t  ctrl,
  input  wire                         bit_in,
  input  wire [sitda_pkg::BCD_W-1:0]  digit_in,
  output logic                        carry_out,
  output logic [sitda_pkg::BCD_W-1:0] digit
);
  import sitda_pkg::*;

  logic [BCD_W-1:0] digit_r;
  logic [BCD_W-1:0] digit_nxt;
  logic [BCD_W-1:0] adj;

  // A digit of five or more overflows when doubled; adding three first
  // makes the carry land in the next digit.
  assign adj       = (digit_r >= BCD_W'(5)) ? (digit_r + BCD_W'(3)) : digit_r;
  assign carry_out = adj[BCD_W-1];
  assign digit     = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[BCD_W-2:0], bit_in};
    end else if (ctrl.move) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

FILE: src/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks for the decimal text converter
// Watches the handshakes and the character stream of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [sitda_pkg::CHAR_W-1:0]  out_character,
  input wire                          out_last
);
  import sitda_pkg::*;

  // A stalled character must hold until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output character changed while stalled");

  // Only a minus sign or a decimal digit ever appears.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == MINUS_SIGN) ||
                  ((out_character >= ASCII_ZERO) && (out_character <= ASCII_ZERO + 8'd9)))
    else $error("output character is not a sign or digit");

  // A minus sign is never the final character of a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == MINUS_SIGN) |-> !out_last)
    else $error("minus sign flagged as last");

  // The converter works on one value at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a conversion is running");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last      (out_last)
);

`default_nettype wire

FILE: sim/sitda_text_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sitda_text_check_pkg: expected-text tracking for the decimal text converter
// Works out the characters each accepted value must produce and checks the
// characters that come out of the block against them, in order.
// ----------------------------------------------------------------------------

package sitda_text_check_pkg;

  import sitda_pkg::*;

  class decimal_text_scoreboard;

    localparam int RADIX      = 10;
    localparam int PRINT_CAP  = 40;

    // One entry per character still owed by the block.
    bit [CHAR_W-1:0] owed_chars[$];
    bit              owed_lasts[$];
    int              owed_values[$];

    int error_count;
    int values_noted;
    int negatives_noted;
    int chars_checked;
    int longest_text;

    function new();
      error_count     = 0;
      values_noted    = 0;
      negatives_noted = 0;
      chars_checked   = 0;
      longest_text    = 0;
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction

    // Appends the decimal text of an accepted value to the owed characters.
    function void note_value(logic signed [DEFAULT_VALUE_WIDTH-1:0] value);
      bit [63:0]       magnitude;
      bit [CHAR_W-1:0] digits[$];
      int              text_len;
      if (value[DEFAULT_VALUE_WIDTH-1]) begin
        magnitude = {{(64-DEFAULT_VALUE_WIDTH){1'b0}}, ~value} + 64'd1;
      end else begin
        magnitude = {{(64-DEFAULT_VALUE_WIDTH){1'b0}}, value};
      end
      do begin
        digits.push_front(CHAR_W'(magnitude % RADIX));
        magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      text_len = digits.size();
      if (value[DEFAULT_VALUE_WIDTH-1]) begin
        owed_chars.push_back(MINUS_SIGN);
        owed_lasts.push_back(1'b0);
        owed_values.push_back(value);
        negatives_noted++;
        text_len++;
      end
      foreach (digits[i]) begin
        owed_chars.push_back(ASCII_ZERO + digits[i]);
        owed_lasts.push_back(i == digits.size() - 1);
        owed_values.push_back(value);
      end
      if (text_len > longest_text) longest_text = text_len;
      values_noted++;
    endfunction

    // Compares one transferred character with the oldest owed one.
    function void check_char(bit [CHAR_W-1:0] character, bit last);
      bit [CHAR_W-1:0] want_char;
      bit              want_last;
      int              source;
      chars_checked++;
      if (owed_chars.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: unexpected character, expected none, actual %0d last %0d",
                   $time, character, last);
        return;
      end
      want_char = owed_chars.pop_front();
      want_last = owed_lasts.pop_front();
      source    = owed_values.pop_front();
      if (character !== want_char) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: character mismatch for value %0d, expected %0d, actual %0d",
                   $time, source, want_char, character);
      end
      if (last !== want_last) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: last flag mismatch for value %0d, expected %0d, actual %0d",
                   $time, source, want_last, last);
      end
    endfunction

  endclass

endpackage

FILE: sim/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core: self-checking bench for the converter
// Feeds signed values through the input channel, predicts the decimal text
// of each one and checks every character and last flag as it comes out.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii_core;

  import sitda_pkg::*;
  import sitda_text_check_pkg::*;

  localparam int VALUE_WIDTH   = DEFAULT_VALUE_WIDTH;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 470;
  // This many quiet cycles after the last check is plenty to catch a
  // stray extra character.
  localparam int DRAIN_CYCLES  = 80;
  // Longest correct quiet stretch: a sender gap, a full conversion and a
  // receiver stall together stay well below this limit.
  localparam int QUIET_LIMIT   = 2000;
  localparam int INT_MAX       = 2147483647;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] in_value  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [CHAR_W-1:0]             out_character;
  logic                          out_last;

  decimal_text_scoreboard text_sb;

  always #5 clk = ~clk;

  signed_int_to_decimal_ascii_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // Both channels are observed at the rising edge. Everything the bench
  // drives changes only at the falling edge, and the block's outputs are
  // read before its own register updates land, so the sampled values are
  // the ones the block saw at that edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      text_sb.note_value(in_value);
    end
    if (rst_n && out_valid && out_ready) begin
      text_sb.check_char(out_character, out_last);
    end
  end

  // Holds one value on the input channel until its transfer. Valid is only
  // raised here and only lowered by the idle task, so a value that follows
  // a transfer directly keeps valid high without a glitch.
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Sender gap. The payload carries junk while valid is low, which the
  // block must not pick up.
  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_value <= $urandom;
    end
  endtask

  // Random value with a bias toward the interesting corners: every digit
  // count, digits of zero inside the number, powers of ten and their
  // neighbors, small values around zero and both ends of the range. The
  // plain uniform share makes every input bit take both values.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    longint lo;
    longint hi;
    longint magnitude;
    int     roll;
    int     digit_count;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return $urandom;
    end else if (roll < 55) begin
      digit_count = $urandom_range(1, 10);
      lo = 1;
      repeat (digit_count - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > INT_MAX) hi = INT_MAX;
      magnitude = lo + longint'({32'd0, $urandom} % (hi - lo + 1));
    end else if (roll < 70) begin
      // Digits are zero half of the time; the leading one never is. A
      // ten-digit number starts with one so that it stays in range.
      digit_count = $urandom_range(2, 10);
      magnitude = (digit_count == 10) ? 1 : $urandom_range(1, 9);
      repeat (digit_count - 1) begin
        magnitude = magnitude * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
      end
    end else if (roll < 80) begin
      return $urandom_range(0, 40) - 20;
    end else if (roll < 90) begin
      magnitude = 1;
      repeat ($urandom_range(0, 9)) magnitude = magnitude * 10;
      magnitude = magnitude + $urandom_range(0, 2) - 1;
    end else begin
      case ($urandom_range(0, 3))
        0:       return INT_MAX;
        1:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        2:       return INT_MAX - $urandom_range(0, 9);
        default: return {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(0, 9);
      endcase
    end
    if ($urandom_range(0, 1)) magnitude = -magnitude;
    return magnitude[VALUE_WIDTH-1:0];
  endfunction

  // Receiver back-pressure. The pattern switches at random intervals
  // between always ready, a random three-in-four, a fixed one-in-four beat
  // and long stalls, so that stalls hit the first character, the middle
  // digits and the flagged last one alike.
  initial begin : receiver_pattern
    int          mode;
    int          span;
    int          hold;
    logic [1:0]  beat;
    hold = 0;
    beat = '0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        beat = beat + 2'd1;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= (beat == 2'd0);
          default: begin
            if (hold == 0) begin
              out_ready <= ~out_ready;
              hold = $urandom_range(1, 20);
            end else begin
              hold--;
            end
          end
        endcase
      end
    end
  end

  // Ends the run if neither channel has made a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d characters still owed",
             $time, QUIET_LIMIT, text_sb.pending());
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [VALUE_WIDTH-1:0] directed_values[$];
    int sent;
    int burst;
    text_sb = new();

    // Directed part: zero, single digits of both signs, the one-digit to
    // two-digit boundary, zero digits inside the number, both ends of the
    // range and the neighbor of the most negative value, and alternating
    // bit patterns.
    directed_values = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      -32'sd100, 32'sd101, -32'sd1005, 32'sd1000000007, -32'sd2000000001,
      32'sd2147483647, 32'sh80000000, 32'sh80000001, 32'sd1000000000,
      -32'sd1000000000, 32'sd999999999, 32'sd1234567890, -32'sd987654321,
      32'sh55555555, 32'shAAAAAAAA, 32'sd7
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
    end

    // Random part in bursts. Some bursts follow each other with no gap at
    // all, so there are stretches with the sender never idle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (sent < RANDOM_ITEMS) begin
          send_value(pick_value());
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 10));
    end
    idle_sender(1);

    while (text_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative) into %0d characters, longest text %0d.",
             text_sb.values_noted, text_sb.negatives_noted, text_sb.chars_checked,
             text_sb.longest_text);
    $display("Errors found: %0d.", text_sb.error_count);
    if (text_sb.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sitda_pkg.sv
src/sitda_bcd_cell.sv
src/signed_int_to_decimal_ascii_core.sv
src/sitda_checker.sv
sim/sitda_text_check_pkg.sv
sim/tb_signed_int_to_decimal_ascii_core.sv
